/* hdl/lhs_pkg.sv */
// Shared types, command codes and constants for the Langevin harmonic step block.
`timescale 1ns / 1ps
`default_nettype none

package lhs_pkg;

  // Fixed-point format: number of fraction bits in every value.
  localparam int unsigned FRAC_BITS = 16;

  // Fixed-point constants one half and one quarter.
  localparam logic signed [31:0] ONE_HALF    = 32'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] ONE_QUARTER = 32'sd1 <<< (FRAC_BITS - 2);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MASS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG_COEFF     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRING_CONST   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAP_CENTER    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SCALE    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_INIT_SCALE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_INIT_SCALE = 4'd7;

  // Configuration reset values.
  localparam logic [16:0]        RST_TIME_STEP      = 17'd3277;
  localparam logic [30:0]        RST_INVERSE_MASS   = 31'd65536;
  localparam logic [30:0]        RST_DRAG_COEFF     = 31'd65536;
  localparam logic [30:0]        RST_SPRING_CONST   = 31'd327680;
  localparam logic signed [31:0] RST_TRAP_CENTER    = 32'sd0;
  localparam logic [30:0]        RST_NOISE_SCALE    = 31'd409781;
  localparam logic [30:0]        RST_POS_INIT_SCALE = 31'd29309;
  localparam logic [30:0]        RST_VEL_INIT_SCALE = 31'd65536;

  // Item kinds carried in the input tuser.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Multiplier operand sources.
  typedef enum logic [4:0] {
    SRC_ZERO,
    SRC_HALF,
    SRC_QUARTER,
    SRC_DT,
    SRC_IM,
    SRC_G,
    SRC_K,
    SRC_NS,
    SRC_PIS,
    SRC_VIS,
    SRC_DRAW_A,
    SRC_DRAW_B,
    SRC_DRAW_C,
    SRC_V,
    SRC_HIM,
    SRC_HDT,
    SRC_T1,
    SRC_ACC1,
    SRC_D,
    SRC_QG,
    SRC_IMIM,
    SRC_C2A,
    SRC_DT2,
    SRC_ACC2,
    SRC_C2
  } mul_src_e;

  // Destinations of a product writeback.
  typedef enum logic [4:0] {
    WB_NONE,
    WB_HIM,
    WB_GV,
    WB_HDT,
    WB_DTV,
    WB_T1,
    WB_DT2,
    WB_T2,
    WB_QG,
    WB_IMIM,
    WB_NN,
    WB_FN,
    WB_C2A,
    WB_C2,
    WB_M1,
    WB_M2,
    WB_XN,
    WB_VN
  } wb_dst_e;

  // Saturating sums.
  typedef enum logic [2:0] {
    ADD_NONE,
    ADD_ACC1,
    ADD_XN,
    ADD_D,
    ADD_ACC2
  } add_op_e;

  // One cycle's command from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_src_e src_a;
    mul_src_e src_b;
    wb_dst_e  wb;
    add_op_e  add;
    logic     commit;
    logic     step;
  } dp_cmd_t;

endpackage

`default_nettype wire

/* hdl/lhs_ctrl.sv */
// Controller: sequences the shared multiplier and adders through one item.
`timescale 1ns / 1ps
`default_nettype none

module lhs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  input  wire logic            s_func_i,
  output logic                 s_ready_o,
  input  wire logic            m_ready_i,
  output logic                 m_valid_o,
  output lhs_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  localparam logic [4:0] LAST_STEP  = 5'd16;
  localparam logic [4:0] LAST_START = 5'd4;

  state_e     state_q;
  logic [4:0] cnt_q;
  logic       func_q;
  logic       out_valid_q;
  logic       accept;
  logic       slot_free;

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;
  assign accept    = s_valid_i && s_ready_o;
  assign slot_free = !out_valid_q || m_ready_i;

  // Microprogram: operand selects, writeback and sum for each cycle of an item.
  always_comb begin
    cmd_o        = '0;
    cmd_o.src_a  = lhs_pkg::SRC_ZERO;
    cmd_o.src_b  = lhs_pkg::SRC_ZERO;
    cmd_o.wb     = lhs_pkg::WB_NONE;
    cmd_o.add    = lhs_pkg::ADD_NONE;
    cmd_o.load   = accept;
    cmd_o.step   = (func_q == lhs_pkg::FUNC_STEP);
    cmd_o.commit = (state_q == ST_DONE) && slot_free;
    if (state_q == ST_RUN) begin
      if (func_q == lhs_pkg::FUNC_STEP) begin
        unique case (cnt_q)
          5'd0: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_HALF; cmd_o.src_b = lhs_pkg::SRC_IM;
          end
          5'd1: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_G; cmd_o.src_b = lhs_pkg::SRC_V;
            cmd_o.wb = lhs_pkg::WB_HIM;
          end
          5'd2: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_HIM; cmd_o.src_b = lhs_pkg::SRC_DT;
            cmd_o.wb = lhs_pkg::WB_GV;
          end
          5'd3: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_DT; cmd_o.src_b = lhs_pkg::SRC_V;
            cmd_o.wb = lhs_pkg::WB_HDT; cmd_o.add = lhs_pkg::ADD_ACC1;
          end
          5'd4: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_HDT; cmd_o.src_b = lhs_pkg::SRC_DT;
            cmd_o.wb = lhs_pkg::WB_DTV;
          end
          5'd5: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_DT; cmd_o.src_b = lhs_pkg::SRC_DT;
            cmd_o.wb = lhs_pkg::WB_T1;
          end
          5'd6: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_T1; cmd_o.src_b = lhs_pkg::SRC_ACC1;
            cmd_o.wb = lhs_pkg::WB_DT2;
          end
          5'd7: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_QUARTER; cmd_o.src_b = lhs_pkg::SRC_G;
            cmd_o.wb = lhs_pkg::WB_T2;
          end
          5'd8: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_IM; cmd_o.src_b = lhs_pkg::SRC_IM;
            cmd_o.wb = lhs_pkg::WB_QG; cmd_o.add = lhs_pkg::ADD_XN;
          end
          5'd9: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_NS; cmd_o.src_b = lhs_pkg::SRC_DRAW_A;
            cmd_o.wb = lhs_pkg::WB_IMIM; cmd_o.add = lhs_pkg::ADD_D;
          end
          5'd10: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_K; cmd_o.src_b = lhs_pkg::SRC_D;
            cmd_o.wb = lhs_pkg::WB_NN;
          end
          5'd11: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_QG; cmd_o.src_b = lhs_pkg::SRC_IMIM;
            cmd_o.wb = lhs_pkg::WB_FN;
          end
          5'd12: begin
            cmd_o.wb = lhs_pkg::WB_C2A; cmd_o.add = lhs_pkg::ADD_ACC2;
          end
          5'd13: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_C2A; cmd_o.src_b = lhs_pkg::SRC_DT2;
          end
          5'd14: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_HDT; cmd_o.src_b = lhs_pkg::SRC_ACC2;
            cmd_o.wb = lhs_pkg::WB_C2;
          end
          5'd15: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_C2; cmd_o.src_b = lhs_pkg::SRC_ACC2;
            cmd_o.wb = lhs_pkg::WB_M1;
          end
          5'd16: begin
            cmd_o.wb = lhs_pkg::WB_M2;
          end
          default: begin
            cmd_o.wb = lhs_pkg::WB_NONE;
          end
        endcase
      end else begin
        unique case (cnt_q)
          5'd0: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_PIS; cmd_o.src_b = lhs_pkg::SRC_DRAW_A;
          end
          5'd1: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_VIS; cmd_o.src_b = lhs_pkg::SRC_DRAW_B;
            cmd_o.wb = lhs_pkg::WB_XN;
          end
          5'd2: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_NS; cmd_o.src_b = lhs_pkg::SRC_DRAW_C;
            cmd_o.wb = lhs_pkg::WB_VN; cmd_o.add = lhs_pkg::ADD_D;
          end
          5'd3: begin
            cmd_o.mul_en = 1'b1; cmd_o.src_a = lhs_pkg::SRC_K; cmd_o.src_b = lhs_pkg::SRC_D;
            cmd_o.wb = lhs_pkg::WB_NN;
          end
          5'd4: begin
            cmd_o.wb = lhs_pkg::WB_FN;
          end
          default: begin
            cmd_o.wb = lhs_pkg::WB_NONE;
          end
        endcase
      end
    end
  end

  // State, cycle counter and output word valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      func_q      <= lhs_pkg::FUNC_START;
      out_valid_q <= 1'b0;
    end else begin
      // A commit raises the output word; a taken word with no commit drops it.
      if (state_q == ST_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            func_q  <= s_func_i;
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          cnt_q <= cnt_q + 5'd1;
          if ((func_q == lhs_pkg::FUNC_STEP && cnt_q == LAST_STEP) ||
              (func_q == lhs_pkg::FUNC_START && cnt_q == LAST_START)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // A result is only committed into a free output slot.
  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!m_valid_o || m_ready_i))
    else $error("result committed over a pending output word");

  // A committed result is offered in the next cycle.
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> m_valid_o)
    else $error("committed result not offered");

  // Every product writeback follows a multiply issued in the previous cycle.
  a_wb_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wb != lhs_pkg::WB_NONE) |-> $past(cmd_o.mul_en))
    else $error("writeback without a product");

  // The block is busy in the cycle after taking a word.
  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !s_ready_o)
    else $error("ready right after accepting a word");

endmodule

`default_nettype wire

/* hdl/lhs_datapath.sv */
// Datapath: configuration registers, particle state, shared multiplier and saturating adders.
`timescale 1ns / 1ps
`default_nettype none

module lhs_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lhs_pkg::dp_cmd_t                cmd_i,
  input  wire logic signed [31:0]              draw_a_i,
  input  wire logic signed [31:0]              draw_b_i,
  input  wire logic signed [31:0]              draw_c_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [lhs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i,
  output logic signed [31:0]                   position_o,
  output logic signed [31:0]                   velocity_o,
  output logic signed [31:0]                   spring_force_o,
  output logic                                 saturated_o
);

  localparam logic signed [34:0] S32_MAX_W = 35'sd2147483647;
  localparam logic signed [34:0] S32_MIN_W = -35'sd2147483648;
  localparam logic signed [31:0] S32_MAX   = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN   = 32'sh80000000;

  // Clip a wide sum to 32 bits; the top bit of the result flags a clip.
  function automatic logic [32:0] sat32(input logic signed [34:0] v);
    logic [32:0] r;
    if (v > S32_MAX_W) begin
      r = {1'b1, S32_MAX};
    end else if (v < S32_MIN_W) begin
      r = {1'b1, S32_MIN};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Configuration registers.
  logic [16:0]        time_step_q;
  logic [30:0]        inverse_mass_q;
  logic [30:0]        drag_coeff_q;
  logic [30:0]        spring_const_q;
  logic signed [31:0] trap_center_q;
  logic [30:0]        noise_scale_q;
  logic [30:0]        pos_init_scale_q;
  logic [30:0]        vel_init_scale_q;

  // Particle state.
  logic signed [31:0] x_q, v_q, f_q, n_q;

  // Latched draws and intermediate results.
  logic signed [31:0] draw_a_q, draw_b_q, draw_c_q;
  logic signed [31:0] him_q, gv_q, hdt_q, dtv_q, t1_q, dt2_q, t2_q, qg_q, imim_q;
  logic signed [31:0] nn_q, fn_q, c2a_q, c2_q, m1_q, m2_q, xn_q, vn_q;
  logic signed [31:0] acc1_q, d_q, acc2_q;
  logic               clip_q;
  logic signed [63:0] prod_q;

  // Output word.
  logic signed [31:0] out_pos_q, out_vel_q, out_force_q;
  logic               out_sat_q;

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod_d;
  logic signed [63:0] prod_sh;
  logic               mul_clip;
  logic signed [31:0] mul_res;
  logic [32:0]        neg_sat;
  logic [32:0]        add_sat;
  logic [32:0]        vn_sat;
  logic               wb_clip;
  logic               add_clip;
  logic signed [31:0] v_d;
  logic               commit_clip;

  // Operand multiplexer for one multiplier input.
  function automatic logic signed [31:0] pick(input lhs_pkg::mul_src_e s);
    logic signed [31:0] r;
    case (s)
      lhs_pkg::SRC_HALF:    r = lhs_pkg::ONE_HALF;
      lhs_pkg::SRC_QUARTER: r = lhs_pkg::ONE_QUARTER;
      lhs_pkg::SRC_DT:      r = signed'({15'd0, time_step_q});
      lhs_pkg::SRC_IM:      r = signed'({1'b0, inverse_mass_q});
      lhs_pkg::SRC_G:       r = signed'({1'b0, drag_coeff_q});
      lhs_pkg::SRC_K:       r = signed'({1'b0, spring_const_q});
      lhs_pkg::SRC_NS:      r = signed'({1'b0, noise_scale_q});
      lhs_pkg::SRC_PIS:     r = signed'({1'b0, pos_init_scale_q});
      lhs_pkg::SRC_VIS:     r = signed'({1'b0, vel_init_scale_q});
      lhs_pkg::SRC_DRAW_A:  r = draw_a_q;
      lhs_pkg::SRC_DRAW_B:  r = draw_b_q;
      lhs_pkg::SRC_DRAW_C:  r = draw_c_q;
      lhs_pkg::SRC_V:       r = v_q;
      lhs_pkg::SRC_HIM:     r = him_q;
      lhs_pkg::SRC_HDT:     r = hdt_q;
      lhs_pkg::SRC_T1:      r = t1_q;
      lhs_pkg::SRC_ACC1:    r = acc1_q;
      lhs_pkg::SRC_D:       r = d_q;
      lhs_pkg::SRC_QG:      r = qg_q;
      lhs_pkg::SRC_IMIM:    r = imim_q;
      lhs_pkg::SRC_C2A:     r = c2a_q;
      lhs_pkg::SRC_DT2:     r = dt2_q;
      lhs_pkg::SRC_ACC2:    r = acc2_q;
      lhs_pkg::SRC_C2:      r = c2_q;
      default:              r = '0;
    endcase
    return r;
  endfunction

  // Shared 32x32 signed multiplier, registered.
  always_comb begin
    op_a   = pick(cmd_i.src_a);
    op_b   = pick(cmd_i.src_b);
    prod_d = 64'(op_a) * 64'(op_b);
  end

  // Product writeback: floor shift, clip to 32 bits, optional negation.
  always_comb begin
    prod_sh  = prod_q >>> lhs_pkg::FRAC_BITS;
    mul_clip = !((&prod_sh[63:31]) || !(|prod_sh[63:31]));
    if (mul_clip) begin
      mul_res = prod_sh[63] ? S32_MIN : S32_MAX;
    end else begin
      mul_res = prod_sh[31:0];
    end
    neg_sat = sat32(-35'(mul_res));
    if (cmd_i.wb == lhs_pkg::WB_NONE) begin
      wb_clip = 1'b0;
    end else if (cmd_i.wb == lhs_pkg::WB_FN) begin
      wb_clip = mul_clip || neg_sat[32];
    end else begin
      wb_clip = mul_clip;
    end
  end

  // Saturating sums.
  always_comb begin
    case (cmd_i.add)
      lhs_pkg::ADD_ACC1: add_sat = sat32(35'(f_q) + 35'(n_q) - 35'(gv_q));
      lhs_pkg::ADD_XN:   add_sat = sat32(35'(x_q) + 35'(dtv_q) + 35'(t2_q));
      lhs_pkg::ADD_D:    add_sat = sat32(35'(xn_q) - 35'(trap_center_q));
      lhs_pkg::ADD_ACC2: add_sat = sat32(35'(f_q) + 35'(fn_q) + 35'(n_q) + 35'(nn_q)
                                         - 35'(gv_q) - 35'(gv_q));
      default:           add_sat = '0;
    endcase
    add_clip = (cmd_i.add != lhs_pkg::ADD_NONE) && add_sat[32];
  end

  // Final velocity of a step item; a start item takes the scaled draw.
  always_comb begin
    vn_sat = sat32(35'(v_q) + 35'(m1_q) - 35'(m2_q));
    if (cmd_i.step) begin
      v_d         = vn_sat[31:0];
      commit_clip = vn_sat[32];
    end else begin
      v_d         = vn_q;
      commit_clip = 1'b0;
    end
  end

  // Configuration and particle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q      <= lhs_pkg::RST_TIME_STEP;
      inverse_mass_q   <= lhs_pkg::RST_INVERSE_MASS;
      drag_coeff_q     <= lhs_pkg::RST_DRAG_COEFF;
      spring_const_q   <= lhs_pkg::RST_SPRING_CONST;
      trap_center_q    <= lhs_pkg::RST_TRAP_CENTER;
      noise_scale_q    <= lhs_pkg::RST_NOISE_SCALE;
      pos_init_scale_q <= lhs_pkg::RST_POS_INIT_SCALE;
      vel_init_scale_q <= lhs_pkg::RST_VEL_INIT_SCALE;
      x_q              <= '0;
      v_q              <= '0;
      f_q              <= '0;
      n_q              <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          lhs_pkg::CFG_TIME_STEP:      time_step_q      <= cfg_data_i[16:0];
          lhs_pkg::CFG_INVERSE_MASS:   inverse_mass_q   <= cfg_data_i[30:0];
          lhs_pkg::CFG_DRAG_COEFF:     drag_coeff_q     <= cfg_data_i[30:0];
          lhs_pkg::CFG_SPRING_CONST:   spring_const_q   <= cfg_data_i[30:0];
          lhs_pkg::CFG_TRAP_CENTER:    trap_center_q    <= signed'(cfg_data_i);
          lhs_pkg::CFG_NOISE_SCALE:    noise_scale_q    <= cfg_data_i[30:0];
          lhs_pkg::CFG_POS_INIT_SCALE: pos_init_scale_q <= cfg_data_i[30:0];
          lhs_pkg::CFG_VEL_INIT_SCALE: vel_init_scale_q <= cfg_data_i[30:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.commit) begin
        x_q <= xn_q;
        v_q <= v_d;
        f_q <= fn_q;
        n_q <= nn_q;
      end
    end
  end

  // Draws, intermediates and output word; payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      draw_a_q <= draw_a_i;
      draw_b_q <= draw_b_i;
      draw_c_q <= draw_c_i;
      clip_q   <= 1'b0;
    end else begin
      clip_q <= clip_q || wb_clip || add_clip;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    case (cmd_i.wb)
      lhs_pkg::WB_HIM:  him_q  <= mul_res;
      lhs_pkg::WB_GV:   gv_q   <= mul_res;
      lhs_pkg::WB_HDT:  hdt_q  <= mul_res;
      lhs_pkg::WB_DTV:  dtv_q  <= mul_res;
      lhs_pkg::WB_T1:   t1_q   <= mul_res;
      lhs_pkg::WB_DT2:  dt2_q  <= mul_res;
      lhs_pkg::WB_T2:   t2_q   <= mul_res;
      lhs_pkg::WB_QG:   qg_q   <= mul_res;
      lhs_pkg::WB_IMIM: imim_q <= mul_res;
      lhs_pkg::WB_NN:   nn_q   <= mul_res;
      lhs_pkg::WB_FN:   fn_q   <= neg_sat[31:0];
      lhs_pkg::WB_C2A:  c2a_q  <= mul_res;
      lhs_pkg::WB_C2:   c2_q   <= mul_res;
      lhs_pkg::WB_M1:   m1_q   <= mul_res;
      lhs_pkg::WB_M2:   m2_q   <= mul_res;
      lhs_pkg::WB_XN:   xn_q   <= mul_res;
      lhs_pkg::WB_VN:   vn_q   <= mul_res;
      default: begin
      end
    endcase
    case (cmd_i.add)
      lhs_pkg::ADD_ACC1: acc1_q <= add_sat[31:0];
      lhs_pkg::ADD_XN:   xn_q   <= add_sat[31:0];
      lhs_pkg::ADD_D:    d_q    <= add_sat[31:0];
      lhs_pkg::ADD_ACC2: acc2_q <= add_sat[31:0];
      default: begin
      end
    endcase
    if (cmd_i.commit) begin
      out_pos_q   <= xn_q;
      out_vel_q   <= v_d;
      out_force_q <= fn_q;
      out_sat_q   <= clip_q || commit_clip;
    end
  end

  assign position_o     = out_pos_q;
  assign velocity_o     = out_vel_q;
  assign spring_force_o = out_force_q;
  assign saturated_o    = out_sat_q;

endmodule

`default_nettype wire

/* hdl/langevin_harmonic_step_top.sv */
// Top level of the Langevin harmonic step block: stream ports, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Advances one particle in a harmonic trap by a modified velocity-Verlet step for
// underdamped Langevin dynamics, in signed fixed point with 16 fraction bits. Every
// input word gives exactly one output word. A start word (tuser 0) scales the three
// draws into initial position, velocity and noise force; a step word (tuser 1) uses
// draw_a as the new noise draw. All arithmetic runs through one shared 32x32
// multiplier with a registered product, so the dependent product chain sets the
// pace: the block takes no new word until the last one is finished. A finished
// word waits in an output register, and the next word is taken and worked on
// while it waits. Configuration writes are always accepted and should be made
// only while the block is idle.
module langevin_harmonic_step_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input stream.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [95:0]                   s_axis_tdata,  // draw_a, draw_b, draw_c
  input  wire logic [0:0]                    s_axis_tuser,  // func
  // Output stream.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [95:0]                        m_axis_tdata,  // position, velocity, spring_force
  output logic [0:0]                         m_axis_tuser,  // saturated
  // Configuration write channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lhs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i
);

  lhs_pkg::dp_cmd_t   cmd;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [31:0] spring_force;
  logic               saturated;

  assign cfg_ready_o = 1'b1;

  lhs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_func_i  (s_axis_tuser[0]),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd)
  );

  lhs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .draw_a_i       (signed'(s_axis_tdata[31:0])),
    .draw_b_i       (signed'(s_axis_tdata[63:32])),
    .draw_c_i       (signed'(s_axis_tdata[95:64])),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .position_o     (position),
    .velocity_o     (velocity),
    .spring_force_o (spring_force),
    .saturated_o    (saturated)
  );

  assign m_axis_tdata = {spring_force, velocity, position};
  assign m_axis_tuser = saturated;

endmodule

`default_nettype wire
